### rtl/stepped_fan_pwm_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepped fan PWM controller
// Each macro checks a property on clk, with the check held off during reset.
// ----------------------------------------------------------------------------
`ifndef STEPPED_FAN_PWM_CONTROLLER_TOP_DEFINES_SVH
`define STEPPED_FAN_PWM_CONTROLLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SPFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spfc assertion failed");
// Next-cycle implication.
`define SPFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spfc assertion failed");
`else
`define SPFC_ASSERT_IMPL(label, ante, cons)
`define SPFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/spfc_pkg.sv
// ----------------------------------------------------------------------------
// spfc_pkg
// Types, register codes and duty ladder of the stepped fan PWM controller.
// ----------------------------------------------------------------------------
package spfc_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int THRESH_W        = 10;
  localparam int DIVIDE_W        = 8;
  localparam int DUTY_W          = 7;
  localparam int PHASE_W         = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 10;
  localparam int LADDER_STEPS    = 8;

  // PWM phase wraps to zero once it reaches this count
  localparam logic [PHASE_W-1:0]  PWM_PERIOD     = 7'd64;
  localparam logic [DUTY_W-1:0]   DUTY_FULL      = 7'd64;
  localparam logic [DUTY_W-1:0]   DUTY_OFF       = 7'd0;
  localparam logic [THRESH_W-1:0] THRESH_RST     = 10'd250;
  localparam logic [DIVIDE_W-1:0] DIVIDE_RST     = 8'd2;
  localparam logic [DIVIDE_W-1:0] DIVIDE_SAT     = 8'd255;

  localparam logic [7:0] LADDER_LIMIT [LADDER_STEPS] = '{
    8'd240, 8'd229, 8'd219, 8'd208, 8'd198, 8'd188, 8'd177, 8'd167
  };
  localparam logic [DUTY_W-1:0] LADDER_DUTY [LADDER_STEPS] = '{
    7'd64, 7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35, 7'd30
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERTEMP_THRESHOLD = 2'd0,
    CFG_TICK_DIVIDE        = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    OP_SLOW = 1'b0,
    OP_PWM  = 1'b1
  } op_t;

  typedef struct packed {
    logic [THRESH_W-1:0] overtemp_threshold;
    logic [DIVIDE_W-1:0] tick_divide;
  } cfg_t;

  typedef struct packed {
    logic              fan_on;
    logic              green_led;
    logic              red_led;
    logic              over_temp;
    logic [DUTY_W-1:0] duty_level;
  } result_t;

endpackage

### rtl/spfc_in_if.sv
// ----------------------------------------------------------------------------
// spfc_in_if
// Tick channel: slow or PWM tick with temperature sample and lock input.
// ----------------------------------------------------------------------------
interface spfc_in_if #(
  parameter int SAMPLE_BITS = spfc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] adc_sample;
  logic                   lock_n;

  modport source (output valid, op, adc_sample, lock_n, input ready);
  modport sink   (input valid, op, adc_sample, lock_n, output ready);
endinterface

### rtl/spfc_out_if.sv
// ----------------------------------------------------------------------------
// spfc_out_if
// Result channel: fan drive, LED levels, over-temperature flag and duty.
// ----------------------------------------------------------------------------
interface spfc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           fan_on;
  logic                           green_led;
  logic                           red_led;
  logic                           over_temp;
  logic [spfc_pkg::DUTY_W-1:0]    duty_level;

  modport source (output valid, fan_on, green_led, red_led, over_temp, duty_level,
                  input ready);
  modport sink   (input valid, fan_on, green_led, red_led, over_temp, duty_level,
                  output ready);
endinterface

### rtl/spfc_cfg_if.sv
// ----------------------------------------------------------------------------
// spfc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spfc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spfc_pkg::CFG_IDX_W-1:0]    index;
  logic [spfc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/spfc_core.sv
// ----------------------------------------------------------------------------
// spfc_core
// Divider, temperature evaluation, LED logic and PWM phase. The state
// registers double as the result register: they change only when a new
// word is loaded into the result stage.
// ----------------------------------------------------------------------------
`include "stepped_fan_pwm_controller_top_defines.svh"

module spfc_core #(
  parameter int SAMPLE_BITS = spfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic                   op,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  input  logic                   lock_n,
  input  spfc_pkg::cfg_t         cfg,
  output spfc_pkg::result_t      result
);

  localparam int CMP_W = (SAMPLE_BITS > spfc_pkg::THRESH_W) ? SAMPLE_BITS : spfc_pkg::THRESH_W;

  logic [spfc_pkg::PHASE_W-1:0]  phase_r, phase_nxt, phase_inc;
  logic [spfc_pkg::DUTY_W-1:0]   duty_r, duty_nxt, ladder_duty;
  logic                          ot_r, ot_nxt;
  logic                          red_r, red_nxt;
  logic                          green_r, green_nxt;
  logic                          fan_r, fan_nxt;
  logic [spfc_pkg::DIVIDE_W-1:0] div_r, div_nxt, div_inc;
  logic                          eval;
  logic                          hot;
  logic [CMP_W-1:0]              sample_x;

  assign sample_x = CMP_W'(adc_sample);
  assign hot      = sample_x > CMP_W'(cfg.overtemp_threshold);

  // first ladder step the sample lies above wins
  always_comb begin
    ladder_duty = spfc_pkg::DUTY_OFF;
    for (int i = spfc_pkg::LADDER_STEPS - 1; i >= 0; i--) begin
      if (sample_x > CMP_W'(spfc_pkg::LADDER_LIMIT[i])) begin
        ladder_duty = spfc_pkg::LADDER_DUTY[i];
      end
    end
  end

  assign div_inc   = (div_r == spfc_pkg::DIVIDE_SAT) ? div_r : div_r + 1'b1;
  assign eval      = div_inc >= cfg.tick_divide;
  assign phase_inc = phase_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    duty_nxt  = duty_r;
    ot_nxt    = ot_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    fan_nxt   = fan_r;
    div_nxt   = div_r;
    if (step_en) begin
      unique case (spfc_pkg::op_t'(op))
        spfc_pkg::OP_SLOW: begin
          div_nxt = eval ? '0 : div_inc;
          if (eval) begin
            ot_nxt   = hot;
            duty_nxt = hot ? spfc_pkg::DUTY_FULL : ladder_duty;
            priority if (hot) begin
              green_nxt = 1'b0;
              red_nxt   = ~red_r;
            end else if (lock_n) begin
              green_nxt = 1'b0;
              red_nxt   = 1'b1;
            end else begin
              green_nxt = 1'b1;
              red_nxt   = 1'b0;
            end
          end
        end
        spfc_pkg::OP_PWM: begin
          // compare after the increment, then wrap
          fan_nxt   = phase_inc < duty_r;
          phase_nxt = (phase_inc >= spfc_pkg::PWM_PERIOD) ? '0 : phase_inc;
        end
        default: begin
          div_nxt = div_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      duty_r  <= '0;
      ot_r    <= 1'b0;
      red_r   <= 1'b0;
      green_r <= 1'b0;
      fan_r   <= 1'b0;
      div_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      duty_r  <= duty_nxt;
      ot_r    <= ot_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      fan_r   <= fan_nxt;
      div_r   <= div_nxt;
    end
  end

  assign result.fan_on     = fan_r;
  assign result.green_led  = green_r;
  assign result.red_led    = red_r;
  assign result.over_temp  = ot_r;
  assign result.duty_level = duty_r;

  `SPFC_ASSERT_IMPL(a_duty_range, 1'b1, duty_r <= spfc_pkg::DUTY_FULL)
  `SPFC_ASSERT_IMPL(a_hot_full_duty, ot_r, duty_r == spfc_pkg::DUTY_FULL && !green_r)
  `SPFC_ASSERT_IMPL(a_phase_range, 1'b1, phase_r < spfc_pkg::PWM_PERIOD)
  `SPFC_ASSERT_NEXT(a_idle_holds, !step_en, duty_r == $past(duty_r) && phase_r == $past(phase_r))

endmodule

### rtl/stepped_fan_pwm_controller_top.sv
// ----------------------------------------------------------------------------
// stepped_fan_pwm_controller_top
// Temperature-stepped fan PWM controller with over-temperature alarm.
//
//   channel | dir | handshake          | word
//   in_ch   | in  | valid/ready        | op, adc_sample, lock_n
//   out_ch  | out | valid/ready        | fan_on, green_led, red_led, over_temp, duty_level
//   cfg_ch  | in  | valid/ready (rdy=1)| index, data
//
// One tick per cycle while out_ch takes each word; a word appears on out_ch once its
// tick has passed the input register, then the state/result register.
// While a result waits on out_ch the input register takes one more tick, then
// in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous) clears the valid flags and core state; threshold 250, divide 2.
// Register writes are taken every cycle and only expected while idle.
// ----------------------------------------------------------------------------
`include "stepped_fan_pwm_controller_top_defines.svh"

module stepped_fan_pwm_controller_top #(
  parameter int SAMPLE_BITS = spfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  spfc_in_if.sink     in_ch,
  spfc_out_if.source  out_ch,
  spfc_cfg_if.sink    cfg_ch
);

  logic                   in_valid_r;
  logic                   op_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   lock_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   adv;
  logic                   in_take;
  spfc_pkg::cfg_t         cfg_r;
  spfc_pkg::result_t      result;

  // move the held tick into the result stage when that stage frees up
  assign adv           = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = !in_valid_r || adv;
  assign in_take       = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = adv || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_take || (in_valid_r && !adv);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_ch.op;
      sample_r <= in_ch.adc_sample;
      lock_r   <= in_ch.lock_n;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overtemp_threshold <= spfc_pkg::THRESH_RST;
      cfg_r.tick_divide        <= spfc_pkg::DIVIDE_RST;
    end else if (cfg_ch.valid) begin
      unique case (spfc_pkg::cfg_idx_t'(cfg_ch.index))
        spfc_pkg::CFG_OVERTEMP_THRESHOLD:
          cfg_r.overtemp_threshold <= cfg_ch.data[spfc_pkg::THRESH_W-1:0];
        spfc_pkg::CFG_TICK_DIVIDE:
          cfg_r.tick_divide <= cfg_ch.data[spfc_pkg::DIVIDE_W-1:0];
        default: begin
          // drop writes to unknown registers
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  spfc_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .op         (op_r),
    .adc_sample (sample_r),
    .lock_n     (lock_r),
    .cfg        (cfg_r),
    .result     (result)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fan_on     = result.fan_on;
  assign out_ch.green_led  = result.green_led;
  assign out_ch.red_led    = result.red_led;
  assign out_ch.over_temp  = result.over_temp;
  assign out_ch.duty_level = result.duty_level;

  `SPFC_ASSERT_IMPL(a_no_adv_when_full, in_valid_r && out_valid_r && !out_ch.ready, !adv)
  `SPFC_ASSERT_NEXT(a_adv_loads_out, adv, out_valid_r)
  `SPFC_ASSERT_NEXT(a_stall_keeps_in, in_valid_r && !adv, in_valid_r && $stable(sample_r))

endmodule

### test/stepped_fan_pwm_controller_top_tb.sv
// ----------------------------------------------------------------------------
// stepped_fan_pwm_controller_top_tb
// Drives slow and PWM ticks through the fan controller under random idling
// and back-pressure. A scoreboard predicts every output word from its own
// copy of the divider, duty ladder, LED and PWM state, and checks each word
// in order. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module stepped_fan_pwm_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = spfc_pkg::SAMPLE_BITS_DEF;
  localparam int PHASE_ITEMS  = 200;
  localparam int IDLE_PCT     = 13;
  localparam int MAX_REPORTS  = 10;
  localparam longint TIMEOUT_NS = 4_000_000;

  // indexes past the register map; writes there must be dropped
  localparam logic [spfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [spfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [spfc_pkg::PHASE_W-1:0] WRAP_COUNT = 7'd64;

  class fan_duty_scoreboard;
    logic [spfc_pkg::THRESH_W-1:0] thresh;
    logic [spfc_pkg::DIVIDE_W-1:0] divide;
    logic [spfc_pkg::PHASE_W-1:0]  phase;
    logic [spfc_pkg::DUTY_W-1:0]   duty;
    logic                          hot;
    logic                          red;
    logic                          green;
    logic                          fan;
    logic [spfc_pkg::DIVIDE_W-1:0] slow_count;
    spfc_pkg::result_t             expected_q[$];
    int                            failures;

    function new();
      thresh     = spfc_pkg::THRESH_RST;
      divide     = spfc_pkg::DIVIDE_RST;
      phase      = '0;
      duty       = '0;
      hot        = 1'b0;
      red        = 1'b0;
      green      = 1'b0;
      fan        = 1'b0;
      slow_count = '0;
      failures   = 0;
    endfunction

    function void write_reg(logic [spfc_pkg::CFG_IDX_W-1:0] idx,
                            logic [spfc_pkg::CFG_DATA_W-1:0] data);
      if (idx == spfc_pkg::CFG_OVERTEMP_THRESHOLD) begin
        thresh = data[spfc_pkg::THRESH_W-1:0];
      end else if (idx == spfc_pkg::CFG_TICK_DIVIDE) begin
        divide = data[spfc_pkg::DIVIDE_W-1:0];
      end
    endfunction

    function void note_tick(spfc_pkg::op_t op, logic [SAMPLE_W-1:0] sample, logic lock_n);
      spfc_pkg::result_t word;
      if (op == spfc_pkg::OP_SLOW) begin
        if (slow_count != spfc_pkg::DIVIDE_SAT) begin
          slow_count = slow_count + 1'b1;
        end
        if (slow_count >= divide) begin
          slow_count = '0;
          hot = (sample > thresh);
          if (hot) begin
            duty = 7'd64;
          end else begin
            duty = (sample > 10'd240) ? 7'd64 :
                   (sample > 10'd229) ? 7'd60 :
                   (sample > 10'd219) ? 7'd55 :
                   (sample > 10'd208) ? 7'd50 :
                   (sample > 10'd198) ? 7'd45 :
                   (sample > 10'd188) ? 7'd40 :
                   (sample > 10'd177) ? 7'd35 :
                   (sample > 10'd167) ? 7'd30 : 7'd0;
          end
          if (hot) begin
            green = 1'b0;
            red   = ~red;
          end else begin
            green = ~lock_n;
            red   = lock_n;
          end
        end
      end else begin
        // compare after the increment, then wrap
        phase = phase + 1'b1;
        fan   = (phase < duty);
        if (phase >= WRAP_COUNT) begin
          phase = '0;
        end
      end
      word.fan_on     = fan;
      word.green_led  = green;
      word.red_led    = red;
      word.over_temp  = hot;
      word.duty_level = duty;
      expected_q.push_back(word);
    endfunction

    function void report(string what, spfc_pkg::result_t want, spfc_pkg::result_t got);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%0t: %s: expected fan=%0b green=%0b red=%0b hot=%0b duty=%0d",
                 $time, what, want.fan_on, want.green_led, want.red_led, want.over_temp,
                 want.duty_level);
        $display("    got fan=%0b green=%0b red=%0b hot=%0b duty=%0d",
                 got.fan_on, got.green_led, got.red_led, got.over_temp, got.duty_level);
      end
    endfunction

    function void check_word(spfc_pkg::result_t got);
      spfc_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report("word with nothing pending", got, got);
      end else begin
        want = expected_q.pop_front();
        if (want.fan_on !== got.fan_on || want.green_led !== got.green_led ||
            want.red_led !== got.red_led || want.over_temp !== got.over_temp ||
            want.duty_level !== got.duty_level) begin
          report("mismatch", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet_mode;
  logic [spfc_pkg::THRESH_W-1:0] cur_thresh;
  spfc_pkg::result_t seen_word;
  fan_duty_scoreboard sb;

  spfc_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_ch();
  spfc_out_if out_ch();
  spfc_cfg_if cfg_ch();

  stepped_fan_pwm_controller_top #(.SAMPLE_BITS(SAMPLE_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_reg(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_tick(spfc_pkg::op_t'(in_ch.op), in_ch.adc_sample, in_ch.lock_n);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_word.fan_on     = out_ch.fan_on;
        seen_word.green_led  = out_ch.green_led;
        seen_word.red_led    = out_ch.red_led;
        seen_word.over_temp  = out_ch.over_temp;
        seen_word.duty_level = out_ch.duty_level;
        sb.check_word(seen_word);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int pick;
    int near;
    pick = $urandom_range(99);
    if (pick < 25) begin
      return SAMPLE_W'($urandom_range(1023));
    end else if (pick < 65) begin
      return SAMPLE_W'($urandom_range(260, 160));
    end else if (pick < 85) begin
      near = int'(cur_thresh) + $urandom_range(6) - 3;
      if (near < 0) near = 0;
      if (near > 1023) near = 1023;
      return SAMPLE_W'(near);
    end else begin
      return $urandom_range(1) ? '1 : '0;
    end
  endfunction

  task automatic send_tick(spfc_pkg::op_t op, logic [SAMPLE_W-1:0] sample, logic lock_n);
    if (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.adc_sample <= sample;
    in_ch.lock_n     <= lock_n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drop valid and hold until every pending word has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(logic [spfc_pkg::THRESH_W-1:0] thresh,
                           logic [spfc_pkg::DIVIDE_W-1:0] divide);
    logic [spfc_pkg::CFG_IDX_W-1:0]  idx [3];
    logic [spfc_pkg::CFG_DATA_W-1:0] val [3];
    idx[0] = spfc_pkg::CFG_OVERTEMP_THRESHOLD;
    val[0] = thresh;
    idx[1] = $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    val[1] = spfc_pkg::CFG_DATA_W'($urandom_range(1023));
    idx[2] = spfc_pkg::CFG_TICK_DIVIDE;
    val[2] = {2'($urandom_range(3)), divide};
    for (int k = 0; k < 3; k++) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_thresh = thresh;
  endtask

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      send_tick(spfc_pkg::op_t'($urandom_range(99) < 55), pick_sample(),
                1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    quiet_mode       = 1'b0;
    cur_thresh       = spfc_pkg::THRESH_RST;
    in_ch.valid      = 1'b0;
    in_ch.op         = spfc_pkg::OP_SLOW;
    in_ch.adc_sample = '0;
    in_ch.lock_n     = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = spfc_pkg::CFG_OVERTEMP_THRESHOLD;
    cfg_ch.data      = '0;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: over temperature, red toggling, boundary at threshold
    send_tick(spfc_pkg::OP_PWM, '0, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, '1, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, '1, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, '1, 1'b0);
    send_tick(spfc_pkg::OP_SLOW, '1, 1'b0);
    send_tick(spfc_pkg::OP_PWM, '0, 1'b0);
    send_tick(spfc_pkg::OP_PWM, '1, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, 10'd251, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, 10'd250, 1'b0);
    drain();

    // zero divide: evaluate every slow tick, walk the ladder boundaries
    configure('1, 8'd0);
    send_tick(spfc_pkg::OP_SLOW, 10'd241, 1'b0);
    send_tick(spfc_pkg::OP_SLOW, 10'd240, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, 10'd229, 1'b0);
    send_tick(spfc_pkg::OP_SLOW, 10'd219, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, 10'd208, 1'b0);
    send_tick(spfc_pkg::OP_PWM, 10'd0, 1'b0);
    send_tick(spfc_pkg::OP_SLOW, 10'd198, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, 10'd188, 1'b0);
    send_tick(spfc_pkg::OP_SLOW, 10'd177, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, 10'd168, 1'b0);
    send_tick(spfc_pkg::OP_SLOW, 10'd167, 1'b1);
    send_tick(spfc_pkg::OP_SLOW, 10'd0, 1'b0);
    drain();

    // lower the divide below the running count
    configure(spfc_pkg::THRESH_RST, 8'd200);
    repeat (4) send_tick(spfc_pkg::OP_SLOW, pick_sample(), 1'($urandom_range(1)));
    drain();
    configure(spfc_pkg::THRESH_RST, 8'd3);
    send_tick(spfc_pkg::OP_SLOW, '1, 1'b0);
    send_tick(spfc_pkg::OP_SLOW, 10'd300, 1'b1);
    drain();

    configure(spfc_pkg::THRESH_RST, spfc_pkg::DIVIDE_RST);
    random_phase(PHASE_ITEMS);
    drain();
    configure('1, 8'd1);
    random_phase(PHASE_ITEMS);
    drain();
    configure('0, 8'd255);
    random_phase(PHASE_ITEMS);
    drain();
    configure(spfc_pkg::THRESH_W'($urandom_range(1023)), 8'd0);
    quiet_mode = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();
    quiet_mode = 1'b0;
    configure(10'd200, spfc_pkg::DIVIDE_W'($urandom_range(8, 1)));
    random_phase(PHASE_ITEMS);
    drain();
    configure('1, 8'd0);
    random_phase(PHASE_ITEMS);
    drain();
    configure('0, 8'd1);
    random_phase(PHASE_ITEMS);
    drain();
    configure(spfc_pkg::THRESH_W'($urandom_range(1023)),
              spfc_pkg::DIVIDE_W'($urandom_range(255)));
    random_phase(PHASE_ITEMS);
    drain();
    repeat (5) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/spfc_pkg.sv
rtl/spfc_in_if.sv
rtl/spfc_out_if.sv
rtl/spfc_cfg_if.sv
rtl/spfc_core.sv
rtl/stepped_fan_pwm_controller_top.sv
test/stepped_fan_pwm_controller_top_tb.sv
